>>> rtl/core/mrf_pkg.sv
package mrf_pkg;

  localparam int DATA_W  = 32;
  localparam int DIM_W   = 7;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_FLIP   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // orientation masks
  localparam logic [2:0] ORI_SWAP = 3'b001;
  localparam logic [2:0] ORI_MROW = 3'b010;
  localparam logic [2:0] ORI_MCOL = 3'b100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_CALC,
    S_FETCH,
    S_RESP
  } state_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic div_run;
    logic calc;
    logic fetch;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_stat_t;

endpackage

>>> rtl/core/mrf_ctrl.sv
module mrf_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [mrf_pkg::OP_W-1:0]     in_opcode,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  mrf_pkg::dp_stat_t            stat,
  output mrf_pkg::dp_cmd_t             cmd
);
  import mrf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && (in_opcode == OP_READ)) state_nxt = S_PREP;
      end
      S_PREP:  state_nxt = stat.need_div ? S_DIV : S_CALC;
      S_DIV: begin
        if (stat.div_last) state_nxt = S_CALC;
      end
      S_CALC:  state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE:  cmd.take     = in_valid;
      S_PREP:  cmd.prep     = 1'b1;
      S_DIV:   cmd.div_run  = 1'b1;
      S_CALC:  cmd.calc     = 1'b1;
      S_FETCH: cmd.fetch    = 1'b1;
      S_RESP:  cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ($past(state_r) == S_PREP || $past(state_r) == S_DIV))
    else $error("divider entered from wrong state");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && stat.div_last) |=> (state_r == S_CALC))
    else $error("divider did not hand off to address calc");

endmodule

>>> rtl/core/mrf_dp.sv
module mrf_dp #(
  parameter int MAX_DIM = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mrf_pkg::dp_cmd_t                  cmd,
  output mrf_pkg::dp_stat_t                 stat,
  input  logic [mrf_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [mrf_pkg::DATA_W-1:0] in_element_in,
  input  logic                              cfg_we,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrf_pkg::DIM_W-1:0]         cfg_data,
  output logic signed [mrf_pkg::DATA_W-1:0] out_element_out,
  output logic [mrf_pkg::DIM_W-1:0]         out_rows_now,
  output logic [mrf_pkg::DIM_W-1:0]         out_cols_now,
  output logic                              out_last_element
);
  import mrf_pkg::*;

  localparam int DIM_MAXV  = (1 << DIM_W) - 1;
  localparam int DIM_CAP   = (MAX_DIM > DIM_MAXV) ? DIM_MAXV : MAX_DIM;
  localparam int POS_W_RAW = $clog2(DIM_CAP * DIM_CAP + 1);
  localparam int POS_W     = (POS_W_RAW < 2) ? 2 : POS_W_RAW;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(POS_W + 1);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > DIM_W'(DIM_CAP)) res = DIM_W'(DIM_CAP);
    return res;
  endfunction

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [DIM_W-1:0]  rows_r, cols_r;
  logic [2:0]        ori_r;
  logic [POS_W-1:0]  lp_r, rp_r;
  logic [DIM_W-1:0]  i_r, j_r;
  logic              cv_r;
  logic [POS_W-1:0]  quo_r;
  logic [DIM_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIM_W-1:0]  r_r, c_r;
  logic              last_r;
  logic signed [DATA_W-1:0] rd_data_r;

  logic              sw;
  logic [DIM_W-1:0]  rn, cn;
  logic [2*DIM_W-1:0] tot_prod, addr_prod;
  logic [POS_W-1:0]  total;
  logic              wrap, last_now;
  logic [DIM_W:0]    sh, sh_diff;
  logic              ge;
  logic [DIM_W-1:0]  rem_nxt;
  logic [POS_W-1:0]  quo_nxt;
  logic [DIM_W-1:0]  a_idx, b_idx, r_nxt, c_nxt, j_inc;
  logic              mem_we;
  logic [AW-1:0]     waddr, raddr;

  assign sw = |(ori_r & ORI_SWAP);
  assign rn = sw ? cols_r : rows_r;
  assign cn = sw ? rows_r : cols_r;

  assign tot_prod = {{DIM_W{1'b0}}, rows_r} * {{DIM_W{1'b0}}, cols_r};
  assign total    = POS_W'(tot_prod);
  assign wrap     = (rp_r >= total);
  assign last_now = (rp_r == total - POS_W'(1));

  assign stat.need_div = !wrap && !cv_r;
  assign stat.div_last = (cnt_r == CNT_W'(1));

  // restoring divider: one quotient bit per cycle, rp / cn
  assign sh      = {rem_r, quo_r[POS_W-1]};
  assign ge      = (sh >= {1'b0, cn});
  assign sh_diff = sh - {1'b0, cn};
  assign rem_nxt = DIM_W'(ge ? sh_diff : sh);
  assign quo_nxt = {quo_r[POS_W-2:0], ge};

  // map current (i,j) back to loaded (r,c)
  assign a_idx = sw ? j_r : i_r;
  assign b_idx = sw ? i_r : j_r;
  assign r_nxt = |(ori_r & ORI_MROW) ? (rows_r - DIM_W'(1) - a_idx) : a_idx;
  assign c_nxt = |(ori_r & ORI_MCOL) ? (cols_r - DIM_W'(1) - b_idx) : b_idx;
  assign j_inc = j_r + DIM_W'(1);

  assign addr_prod = {{DIM_W{1'b0}}, r_r} * {{DIM_W{1'b0}}, cols_r}
                   + {{DIM_W{1'b0}}, c_r};

  assign mem_we = cmd.take && (in_opcode == OP_LOAD) && (lp_r < total);
  assign waddr  = AW'(lp_r);
  assign raddr  = AW'(addr_prod);

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= in_element_in;
    if (cmd.fetch) rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(1);
      cols_r <= DIM_W'(1);
      ori_r  <= '0;
      lp_r   <= '0;
      rp_r   <= '0;
      i_r    <= '0;
      j_r    <= '0;
      cv_r   <= 1'b1;
      cnt_r  <= '0;
    end else begin
      if (cmd.take) begin
        case (in_opcode)
          OP_LOAD: begin
            if (lp_r < total) lp_r <= lp_r + POS_W'(1);
          end
          OP_ROTATE: begin
            ori_r <= ori_r ^ (sw ? ORI_MROW : ORI_MCOL) ^ ORI_SWAP;
            cv_r  <= 1'b0;
          end
          OP_FLIP: begin
            ori_r <= ori_r ^ (sw ? ORI_MCOL : ORI_MROW);
            cv_r  <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.prep) begin
        if (wrap) begin
          rp_r <= '0;
          i_r  <= '0;
          j_r  <= '0;
          cv_r <= 1'b1;
        end else if (!cv_r) begin
          cnt_r <= CNT_W'(POS_W);
        end
      end
      if (cmd.div_run) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (stat.div_last) begin
          i_r  <= DIM_W'(quo_nxt);
          j_r  <= rem_nxt;
          cv_r <= 1'b1;
        end
      end
      if (cmd.fetch) begin
        if (last_now) begin
          rp_r <= '0;
          i_r  <= '0;
          j_r  <= '0;
        end else begin
          rp_r <= rp_r + POS_W'(1);
          if (j_inc == cn) begin
            j_r <= '0;
            i_r <= i_r + DIM_W'(1);
          end else begin
            j_r <= j_inc;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS: rows_r <= clamp_dim(cfg_data);
          CFG_COLS: cols_r <= clamp_dim(cfg_data);
          default: ;
        endcase
        cv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep && !wrap && !cv_r) begin
      quo_r <= rp_r;
      rem_r <= '0;
    end else if (cmd.div_run) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.calc) begin
      r_r <= r_nxt;
      c_r <= c_nxt;
    end
    if (cmd.fetch) last_r <= last_now;
    if (cmd.out_load) begin
      out_element_out  <= rd_data_r;
      out_rows_now     <= rn;
      out_cols_now     <= cn;
      out_last_element <= last_r;
    end
  end

  a_coord_match: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r |-> (int'(i_r) * int'(cn) + int'(j_r) == int'(rp_r)))
    else $error("row/column counters out of step with read position");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r |-> (j_r < cn))
    else $error("column counter beyond current width");

  a_fetch_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> (cv_r && (int'(addr_prod) < int'(total))))
    else $error("read address outside loaded matrix");

endmodule

>>> rtl/core/matrix_rotate_flip_engine.sv
// Matrix rotate/flip engine.
// Input channel (in_valid/in_ready, in_opcode, in_element_in) takes load,
// rotate, flip and read transactions. Loads fill the store in row-major order
// of the loaded matrix; rotate and flip only update a 3-bit orientation, and
// reads return the next element of the transformed matrix on the output
// channel (out_valid/out_ready) with the current dimensions and a last flag.
// Dimensions come from the cfg_we/cfg_index/cfg_data write port; write it only
// while the block is idle.
// A read holds the input side while it steps through prepare, divide when
// needed, address, memory read and output load; out_valid rises once the
// output register is loaded. After a transform or a dimension write the first
// read adds a restoring divide of the read position, one bit per cycle over
// ceil(log2(dim_cap^2 + 1)) quotient bits, unless the position is past the end.
// The output register parts the two sides: new transactions are taken while a
// result waits. If the receiver stalls, the next read waits in its output
// stage until the pending result is taken.
// Reset (rst_n, synchronous) sets 1x1 dimensions, identity orientation and
// zero load/read positions; store contents are undefined until loaded.
module matrix_rotate_flip_engine #(
  parameter int MAX_DIM = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mrf_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [mrf_pkg::DATA_W-1:0] in_element_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mrf_pkg::DATA_W-1:0] out_element_out,
  output logic [mrf_pkg::DIM_W-1:0]         out_rows_now,
  output logic [mrf_pkg::DIM_W-1:0]         out_cols_now,
  output logic                              out_last_element,
  input  logic                              cfg_we,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrf_pkg::DIM_W-1:0]         cfg_data
);
  import mrf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mrf_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_element_in    (in_element_in),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_element_out  (out_element_out),
    .out_rows_now     (out_rows_now),
    .out_cols_now     (out_cols_now),
    .out_last_element (out_last_element)
  );

endmodule
